// ===== sv/sssd_pkg.sv =====
// shared types, constants and segment tables for the seven-segment scan driver
package sssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 2;
    localparam int VALUE_W     = 14;
    localparam int SEG_W       = 8;
    localparam int EN_W        = 3;
    localparam int MODE_W      = 2;
    localparam int TICK_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int DEC_DIGITS  = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // last scan position before the wrap; the position register never exceeds three
    localparam logic [POS_W-1:0] SCAN_LAST =
        POS_W'((DIGIT_COUNT < 4 ? DIGIT_COUNT : 4) - 1);

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(9999);

    localparam logic [MODE_W-1:0] MODE_NUMBER4 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NUMBER3 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BAR     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_MODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_DIGIT = 1'b1;

    localparam logic [MODE_W-1:0] DISPLAY_MODE_RESET    = MODE_NUMBER4;
    localparam logic [TICK_W-1:0] TICKS_PER_DIGIT_RESET = 8'd6;

    localparam logic [SEG_W-1:0] BAR_PORT_B = 8'h23;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t digits_t [DEC_DIGITS];

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
    } scan_ctrl_t;

    typedef struct packed {
        logic [SEG_W-1:0] port_d;
        logic [SEG_W-1:0] port_b;
        logic [EN_W-1:0]  enable;
    } seg_result_t;

    function automatic logic [SEG_W-1:0] seg_d_lookup(input digit_t d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h28;
            4'd1:    s = 8'hE8;
            4'd2:    s = 8'h30;
            4'd3:    s = 8'hA0;
            4'd4:    s = 8'hE0;
            4'd5:    s = 8'hA0;
            4'd6:    s = 8'h20;
            4'd7:    s = 8'hE8;
            4'd8:    s = 8'h20;
            4'd9:    s = 8'hA0;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [SEG_W-1:0] seg_b_lookup(input digit_t d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 8'h00;
            4'd1:    s = 8'h03;
            4'd2:    s = 8'h01;
            4'd3:    s = 8'h01;
            4'd4:    s = 8'h02;
            4'd5:    s = 8'h20;
            4'd6:    s = 8'h20;
            4'd7:    s = 8'h01;
            4'd8:    s = 8'h00;
            4'd9:    s = 8'h00;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [VALUE_W-1:0] bar_lo(input logic [POS_W-1:0] pos);
        logic [VALUE_W-1:0] t;
        unique case (pos)
            2'd0: t = VALUE_W'(50);
            2'd1: t = VALUE_W'(383);
            2'd2: t = VALUE_W'(649);
            2'd3: t = VALUE_W'(895);
        endcase
        return t;
    endfunction

    function automatic logic [VALUE_W-1:0] bar_hi(input logic [POS_W-1:0] pos);
        logic [VALUE_W-1:0] t;
        unique case (pos)
            2'd0: t = VALUE_W'(255);
            2'd1: t = VALUE_W'(511);
            2'd2: t = VALUE_W'(767);
            2'd3: t = VALUE_W'(1022);
        endcase
        return t;
    endfunction

endpackage

// ===== sv/sssd_digit_split.sv =====
// saturating decimal split of the value into thousands, hundreds, tens and units
module sssd_digit_split
    import sssd_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    output digits_t            digits
);

    logic [VALUE_W-1:0] n;
    logic [9:0]         r1;
    logic [6:0]         r2;
    logic [3:0]         r3;
    digit_t             th;
    digit_t             hu;
    digit_t             te;

    // compare ladder per decade, remainder carried to the next decade
    always_comb
    begin
        n  = (value > VALUE_MAX) ? VALUE_MAX : value;
        th = '0;
        r1 = n[9:0];
        for (int k = 1; k <= 9; k++)
        begin
            if (n >= VALUE_W'(k * 1000))
            begin
                th = DIGIT_W'(k);
                r1 = 10'(n - VALUE_W'(k * 1000));
            end
        end
        hu = '0;
        r2 = r1[6:0];
        for (int k = 1; k <= 9; k++)
        begin
            if (r1 >= 10'(k * 100))
            begin
                hu = DIGIT_W'(k);
                r2 = 7'(r1 - 10'(k * 100));
            end
        end
        te = '0;
        r3 = r2[3:0];
        for (int k = 1; k <= 9; k++)
        begin
            if (r2 >= 7'(k * 10))
            begin
                te = DIGIT_W'(k);
                r3 = 4'(r2 - 7'(k * 10));
            end
        end
    end

    assign digits[0] = th;
    assign digits[1] = hu;
    assign digits[2] = te;
    assign digits[3] = r3;

endmodule

// ===== sv/sssd_segment_encode.sv =====
// per-mode segment pattern and digit enable for the scanned position
module sssd_segment_encode
    import sssd_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    input  digits_t            digits,
    input  scan_ctrl_t         ctrl,
    output seg_result_t        result
);

    digit_t          d;
    logic [EN_W-1:0] en;

    assign d  = digits[ctrl.pos];
    assign en = EN_W'({1'b0, ctrl.pos}) + EN_W'(1);

    always_comb
    begin
        result = '0;
        unique case (ctrl.mode)
            MODE_NUMBER4, MODE_NUMBER3:
            begin
                // three-digit mode leaves the first position dark
                if (!(ctrl.mode == MODE_NUMBER3 && ctrl.pos == '0))
                begin
                    result.port_d = seg_d_lookup(d);
                    result.port_b = seg_b_lookup(d);
                    result.enable = en;
                end
            end
            MODE_BAR:
            begin
                if (value != '0)
                begin
                    if (value > bar_hi(ctrl.pos))
                        result.port_d = 8'h68;
                    else if (value > bar_lo(ctrl.pos))
                        result.port_d = 8'h78;
                    else
                        result.port_d = 8'hF8;
                    result.port_b = BAR_PORT_B;
                    result.enable = en;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// ===== sv/sssd_scan_prescaler.sv =====
// tick prescaler and scan position counter
module sssd_scan_prescaler
    import sssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [TICK_W-1:0] ticks_per_digit,
    output logic [POS_W-1:0]  scan_pos
);

    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [POS_W-1:0]  scan_pos_reg;
    logic [POS_W-1:0]  scan_pos_next;
    logic [TICK_W-1:0] limit;
    logic [TICK_W:0]   cnt;

    // a zero setting behaves as one tick per digit
    assign limit = (ticks_per_digit == '0) ? TICK_W'(1) : ticks_per_digit;
    assign cnt   = {1'b0, tick_count_reg} + (TICK_W+1)'(1);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        scan_pos_next   = scan_pos_reg;
        if (advance)
        begin
            if (cnt >= {1'b0, limit})
            begin
                tick_count_next = '0;
                scan_pos_next   = (scan_pos_reg == SCAN_LAST) ? '0
                                : scan_pos_reg + POS_W'(1);
            end
            else
            begin
                tick_count_next = cnt[TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            scan_pos_reg   <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            scan_pos_reg   <= scan_pos_next;
        end
    end

    assign scan_pos = scan_pos_reg;

endmodule

// ===== sv/seven_segment_scan_driver_unit.sv =====
// top level of the multiplexed four-digit seven-segment scan driver
//
// Each accepted item is one timer tick carrying the value to show. The block
// returns one result item per tick: the two segment port bytes and the digit
// that is lit, taken at the scan position held before the tick; the tick then
// advances the prescaler, which steps the scan position every ticks_per_digit
// ticks (zero counts as one) and wraps after the last digit. An item can be
// accepted on every clock cycle while result_ready stays high. The accepting
// edge loads the input register; the result register then loads from it when
// it is free, and the result is on the outputs from that load. The work between
// the two registers is the decimal compare ladder and the table lookup. A
// held-off result stalls the input only once both registers are full.
// Configuration writes take effect at once and are accepted on every cycle.
module seven_segment_scan_driver_unit
    import sssd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // tick items
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [VALUE_W-1:0]     value,
    // result items
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [SEG_W-1:0]       segment_port_d,
    output logic [SEG_W-1:0]       segment_port_b,
    output logic [EN_W-1:0]        digit_enable,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [MODE_W-1:0]  display_mode_reg;
    logic [TICK_W-1:0]  ticks_per_digit_reg;

    // input stage
    logic               s1_valid_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic [POS_W-1:0]   s1_pos_reg;

    // result stage
    logic               result_valid_reg;
    seg_result_t        result_reg;

    logic               item_accept;
    logic               result_advance;
    logic [POS_W-1:0]   scan_pos;
    digits_t            digits;
    scan_ctrl_t         ctrl;
    seg_result_t        result_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg    <= DISPLAY_MODE_RESET;
            ticks_per_digit_reg <= TICKS_PER_DIGIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_MODE:    display_mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_TICKS_PER_DIGIT: ticks_per_digit_reg <= cfg_data[TICK_W-1:0];
            endcase
        end
    end

    // result register frees up when empty or taken; input stage moves when
    // the result register can take its item
    assign result_advance = !result_valid_reg || result_ready;
    assign item_ready     = !s1_valid_reg || result_advance;
    assign item_accept    = item_valid && item_ready;

    // prescaler steps on each accepted tick
    sssd_scan_prescaler u_prescaler (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (item_accept),
        .ticks_per_digit (ticks_per_digit_reg),
        .scan_pos        (scan_pos)
    );

    // input register keeps the position seen before the tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item_ready)
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_value_reg <= value;
            s1_pos_reg   <= scan_pos;
        end
    end

    // decode between the input and result registers
    sssd_digit_split u_split (
        .value  (s1_value_reg),
        .digits (digits)
    );

    assign ctrl.mode = display_mode_reg;
    assign ctrl.pos  = s1_pos_reg;

    sssd_segment_encode u_encode (
        .value  (s1_value_reg),
        .digits (digits),
        .ctrl   (ctrl),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (result_advance)
            result_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (result_advance && s1_valid_reg)
            result_reg <= result_next;
    end

    assign result_valid   = result_valid_reg;
    assign segment_port_d = result_reg.port_d;
    assign segment_port_b = result_reg.port_b;
    assign digit_enable   = result_reg.enable;

    // a dark digit drives no segments
    a_dark_digit_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && digit_enable == '0 |-> segment_port_d == '0 && segment_port_b == '0)
        else $error("segments driven with no digit enabled");

    // enable never names a digit beyond the fourth
    a_enable_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> digit_enable <= EN_W'(4))
        else $error("digit enable out of range");

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result register");

    // scan position stays within the wrap
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pos <= SCAN_LAST)
        else $error("scan position past last digit");

    // scan only moves on an accepted tick
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !item_accept |=> $stable(scan_pos))
        else $error("scan position moved without a tick");

endmodule
